// ===== hdl/cmas_pkg.sv =====
// Shared types, codes and constants for the cartridge mapper address scramble core.
// No dependencies; imported by every module of the core.
package cmas_pkg;

   typedef enum logic [2:0] {
      MODE_REG_WRITE = 3'd0,
      MODE_REG_READ  = 3'd1,
      MODE_PRG_ADDR  = 3'd2,
      MODE_PRG_DATA  = 3'd3,
      MODE_PAT_READ  = 3'd4,
      MODE_NT_READ   = 3'd5,
      MODE_UNUSED6   = 3'd6,
      MODE_UNUSED7   = 3'd7
   } access_mode_type;

   localparam logic [3:0] REG_PAGE      = 4'h5;
   localparam logic [2:0] SEL_MODE      = 3'd0;
   localparam logic [2:0] SEL_BANK      = 3'd1;
   localparam logic [2:0] SEL_TOGGLE    = 3'd3;
   localparam logic [2:0] SEL_INDEX     = 3'd4;
   localparam logic [2:0] SEL_PROT      = 3'd5;

   localparam logic [7:0] MODE_RESET    = 8'h0E;
   localparam logic [7:0] OPEN_BUS_KEEP = 8'hD8;
   localparam logic [9:0] NT_ATTR_START = 10'h3C0;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] address;
      logic [7:0]  data;
      logic [7:0]  open_bus;
   } request_type;

   typedef struct packed {
      logic        nt_page;
      logic [16:0] rom_address;
      logic [7:0]  read_data;
   } response_type;

   typedef struct packed {
      logic [7:0] mode_reg;
      logic [7:0] index_reg;
      logic [7:0] bank_switch_reg;
      logic [9:0] last_nt_offset;
      logic       toggle_bit;
   } mapper_regs_type;

   typedef struct packed {
      logic       wr_mode;
      logic       wr_bank;
      logic       wr_index;
      logic       wr_nt;
      logic       flip_toggle;
      logic [7:0] wdata;
      logic [9:0] nt_offset;
   } update_type;

   function automatic logic [7:0] prot_value(input logic [3:0] idx);
      logic [7:0] v;
      unique case (idx)
         4'h1:    v = 8'h09;
         4'h7:    v = 8'h20;
         4'h8:    v = 8'h04;
         4'hF:    v = 8'h02;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [11:0] rev12(input logic [11:0] v);
      logic [11:0] r;
      for (int i = 0; i < 12; i++) begin
         r[i] = v[11 - i];
      end
      return r;
   endfunction

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7 - i];
      end
      return r;
   endfunction

endpackage

// ===== hdl/cmas_state.sv =====
// Mapper register file: mode, index, bank-switch, nametable offset and toggle bit.
// Depends on cmas_pkg.
module cmas_state
   import cmas_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  update_type      upd,
   output mapper_regs_type state
);

   mapper_regs_type state_ff;
   mapper_regs_type state_in;

   always_comb begin
      state_in = state_ff;
      if (enable) begin
         if (upd.wr_mode)     state_in.mode_reg        = upd.wdata;
         if (upd.wr_bank)     state_in.bank_switch_reg = upd.wdata;
         if (upd.wr_index)    state_in.index_reg       = upd.wdata;
         if (upd.wr_nt)       state_in.last_nt_offset  = upd.nt_offset;
         if (upd.flip_toggle) state_in.toggle_bit      = ~state_ff.toggle_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode_reg        <= MODE_RESET;
         state_ff.index_reg       <= '0;
         state_ff.bank_switch_reg <= '0;
         state_ff.last_nt_offset  <= '0;
         state_ff.toggle_bit      <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// ===== hdl/cmas_datapath.sv =====
// Combinational decode of one bus access: result fields and register updates.
// Depends on cmas_pkg.
module cmas_datapath
   import cmas_pkg::*;
(
   input  request_type     req,
   input  mapper_regs_type state,
   output response_type    rsp,
   output update_type      upd
);

   logic            in_page5;
   logic [2:0]      sel;
   logic [14:0]     prg_off;
   logic [12:0]     chr_addr;
   access_mode_type mode;

   assign mode     = access_mode_type'(req.mode);
   assign in_page5 = (req.address[15:12] == REG_PAGE);
   assign sel      = req.address[10:8];

   always_comb begin
      prg_off = req.address[14:0];
      if (state.mode_reg[0]) prg_off[11:0] = rev12(req.address[11:0]);
      chr_addr = req.address[12:0];
      if (state.mode_reg[7]) begin
         chr_addr[3]  = state.last_nt_offset[0];
         chr_addr[12] = state.last_nt_offset[9];
      end
   end

   always_comb begin
      rsp           = '0;
      upd           = '0;
      upd.wdata     = req.data;
      upd.nt_offset = req.address[9:0];
      unique case (mode)
         MODE_REG_WRITE: begin
            if (in_page5) begin
               upd.wr_mode  = (sel == SEL_MODE);
               upd.wr_bank  = (sel == SEL_BANK);
               upd.wr_index = (sel == SEL_INDEX);
            end
         end
         MODE_REG_READ: begin
            if (in_page5) begin
               if (sel == SEL_TOGGLE) begin
                  upd.flip_toggle = 1'b1;
                  rsp.read_data   = {5'b0, ~state.toggle_bit, 2'b0};
               end else if (sel == SEL_PROT) begin
                  rsp.read_data = (req.open_bus & OPEN_BUS_KEEP)
                                | prot_value(state.index_reg[7:4]);
               end else begin
                  rsp.read_data = req.open_bus;
               end
            end
         end
         MODE_PRG_ADDR: rsp.rom_address = {state.mode_reg[6:5], prg_off};
         MODE_PRG_DATA: rsp.read_data = state.mode_reg[0] ? rev8(req.data) : req.data;
         MODE_PAT_READ: rsp.rom_address = {4'b0, chr_addr};
         MODE_NT_READ: begin
            upd.wr_nt   = (req.address[9:0] < NT_ATTR_START);
            rsp.nt_page = state.bank_switch_reg[1] ? req.address[10] : req.address[11];
         end
         default: ;
      endcase
   end

endmodule

// ===== hdl/cartridge_mapper_addr_scramble_core.sv =====
// Top level of the cartridge mapper address scramble core: request and response
// registers around the decode datapath and mapper registers. Depends on cmas_pkg,
// cmas_datapath and cmas_state.
//
// Usage: each request is one CPU or PPU bus access. req_tuser carries the access
// kind, req_tdata the address, write/ROM data and open bus value. Every request
// yields exactly one response on rsp_ with read data, ROM/CHR address and the
// nametable page bit; fields that do not apply to the access kind are zero.
// After acceptance a request passes the request register, then the response register,
// where rsp_tvalid rises; the response register loads only while it is free.
// Throughput is one request per clock while the receiver does not stall, set by the single
// decode stage between the two registers; mapper register updates land as the request
// moves into the response register, so the next request already sees them.
// Reset (synchronous, active high) empties both registers and sets the mode
// register to 0x0E, all other mapper state to zero.
// When the receiver stalls, the response register holds; the request register
// still takes one more request, after which req_tready drops until rsp_tready.
module cartridge_mapper_addr_scramble_core
   import cmas_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // address[15:0], data[23:16], open_bus[31:24]
   input  logic [2:0]  req_tuser,  // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // read_data[7:0], rom_address[24:8], nt_page[25]
);

   logic            req_valid_ff, req_valid_in;
   request_type     req_ff, req_in;
   logic            rsp_valid_ff, rsp_valid_in;
   response_type    rsp_ff, rsp_in;
   response_type    rsp_calc;
   update_type      upd;
   mapper_regs_type state;
   logic            out_free;
   logic            advance;
   logic            req_take;

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign advance    = req_valid_ff & out_free;
   assign req_tready = ~req_valid_ff | out_free;
   assign req_take   = req_tvalid & req_tready;

   always_comb begin
      req_in          = req_ff;
      req_valid_in    = req_valid_ff;
      if (advance) req_valid_in = 1'b0;
      if (req_take) begin
         req_valid_in     = 1'b1;
         req_in.mode      = req_tuser;
         req_in.address   = req_tdata[15:0];
         req_in.data      = req_tdata[23:16];
         req_in.open_bus  = req_tdata[31:24];
      end
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = req_valid_ff;
         rsp_in       = rsp_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   cmas_datapath u_datapath (
      .req   (req_ff),
      .state (state),
      .rsp   (rsp_calc),
      .upd   (upd)
   );

   cmas_state u_state (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .upd    (upd),
      .state  (state)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.nt_page, rsp_ff.rom_address, rsp_ff.read_data};

endmodule

// ===== tb/cartridge_mapper_addr_scramble_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for cartridge_mapper_addr_scramble_core: a directed table, then
// random bus accesses under bursty requests and receiver stalls, each response scored against
// the table's expected value or a local mapper predictor. Depends on cmas_pkg and the core RTL.
module cartridge_mapper_addr_scramble_core_test
   import cmas_pkg::*;
();

   localparam int RANDOM_COUNT   = 1450;
   localparam int DRAIN_INTERVAL = 400;

   localparam logic [15:0] ADDR_MODE   = {REG_PAGE, 1'b0, SEL_MODE, 8'h00};
   localparam logic [15:0] ADDR_BANK   = {REG_PAGE, 1'b0, SEL_BANK, 8'h00};
   localparam logic [15:0] ADDR_TOGGLE = {REG_PAGE, 1'b0, SEL_TOGGLE, 8'h00};
   localparam logic [15:0] ADDR_INDEX  = {REG_PAGE, 1'b0, SEL_INDEX, 8'h00};
   localparam logic [15:0] ADDR_PROT   = {REG_PAGE, 1'b0, SEL_PROT, 8'h00};

   typedef struct packed {
      access_mode_type mode;
      logic [15:0]     address;
      logic [7:0]      data;
      logic [7:0]      open_bus;
      logic            known;
      logic [7:0]      read_data;
      logic [16:0]     rom_address;
      logic            nt_page;
   } vector_type;

   localparam int DIRECTED_COUNT = 28;

   vector_type directed_vectors [DIRECTED_COUNT] = '{
      '{MODE_REG_READ,  ADDR_TOGGLE,    8'h00, 8'hFF, 1'b1, 8'h04, 17'h0,     1'b0},
      '{MODE_REG_READ,  ADDR_TOGGLE,    8'h00, 8'h00, 1'b1, 8'h00, 17'h0,     1'b0},
      '{MODE_REG_READ,  ADDR_PROT,      8'h00, 8'hFF, 1'b1, 8'hD8, 17'h0,     1'b0},
      '{MODE_REG_READ,  16'h50FF,       8'h00, 8'hA5, 1'b1, 8'hA5, 17'h0,     1'b0},
      '{MODE_REG_READ,  16'h6300,       8'h00, 8'hFF, 1'b1, 8'h00, 17'h0,     1'b0},
      '{MODE_PRG_ADDR,  16'hFFFF,       8'h00, 8'h00, 1'b1, 8'h00, 17'h07FFF, 1'b0},
      '{MODE_PRG_ADDR,  16'h0000,       8'hFF, 8'hFF, 1'b1, 8'h00, 17'h0,     1'b0},
      '{MODE_PRG_DATA,  16'h0000,       8'h81, 8'h00, 1'b1, 8'h81, 17'h0,     1'b0},
      '{MODE_PAT_READ,  16'hFFFF,       8'h00, 8'h00, 1'b1, 8'h00, 17'h01FFF, 1'b0},
      '{MODE_NT_READ,   16'h2BBF,       8'h00, 8'h00, 1'b1, 8'h00, 17'h0,     1'b1},
      '{MODE_NT_READ,   16'h27FF,       8'h00, 8'h00, 1'b1, 8'h00, 17'h0,     1'b0},
      '{MODE_UNUSED6,   16'hFFFF,       8'hFF, 8'hFF, 1'b1, 8'h00, 17'h0,     1'b0},
      '{MODE_UNUSED7,   16'hFFFF,       8'hFF, 8'hFF, 1'b1, 8'h00, 17'h0,     1'b0},
      '{MODE_REG_WRITE, ADDR_MODE,      8'hE1, 8'hFF, 1'b1, 8'h00, 17'h0,     1'b0},
      '{MODE_PRG_ADDR,  16'h7FFF,       8'h00, 8'h00, 1'b0, 8'h00, 17'h0,     1'b0},
      '{MODE_PRG_ADDR,  16'h0001,       8'h00, 8'h00, 1'b0, 8'h00, 17'h0,     1'b0},
      '{MODE_PRG_DATA,  16'h0000,       8'h01, 8'h00, 1'b0, 8'h00, 17'h0,     1'b0},
      '{MODE_NT_READ,   16'h2201,       8'h00, 8'h00, 1'b0, 8'h00, 17'h0,     1'b0},
      '{MODE_NT_READ,   16'h23C0,       8'h00, 8'h00, 1'b0, 8'h00, 17'h0,     1'b0},
      '{MODE_PAT_READ,  16'h0000,       8'h00, 8'h00, 1'b0, 8'h00, 17'h0,     1'b0},
      '{MODE_REG_WRITE, ADDR_BANK,      8'h02, 8'h00, 1'b1, 8'h00, 17'h0,     1'b0},
      '{MODE_NT_READ,   16'h2400,       8'h00, 8'h00, 1'b0, 8'h00, 17'h0,     1'b0},
      '{MODE_REG_WRITE, ADDR_INDEX,     8'h10, 8'h00, 1'b1, 8'h00, 17'h0,     1'b0},
      '{MODE_REG_READ,  ADDR_PROT,      8'h00, 8'h00, 1'b0, 8'h00, 17'h0,     1'b0},
      '{MODE_REG_WRITE, ADDR_INDEX,     8'hF0, 8'h00, 1'b1, 8'h00, 17'h0,     1'b0},
      '{MODE_REG_READ,  ADDR_PROT,      8'h00, 8'hFF, 1'b0, 8'h00, 17'h0,     1'b0},
      '{MODE_REG_WRITE, ADDR_BANK + 16'h0100, 8'hFF, 8'h00, 1'b1, 8'h00, 17'h0, 1'b0},
      '{MODE_REG_WRITE, 16'h4000,       8'h00, 8'h00, 1'b1, 8'h00, 17'h0,     1'b0}
   };

   localparam logic [7:0] GUARD_LUT [16] = '{
      8'h00, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20,
      8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   logic [7:0]  shadow_mode = MODE_RESET;
   logic [7:0]  shadow_index = '0;
   logic [7:0]  shadow_bank = '0;
   logic [9:0]  shadow_nt_offset = '0;
   logic        shadow_toggle = 1'b0;

   response_type pending_responses [$];
   int          mismatch_count = 0;
   int          checked_count = 0;
   int          mode_counts [8] = '{default: 0};
   int          drain_count = 0;
   longint      cycle_count = 0;

   cartridge_mapper_addr_scramble_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // address[15:0], data[23:16], open_bus[31:24]
      .req_tuser  (req_tuser),   // mode[2:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // read_data[7:0], rom_address[24:8], nt_page[25]
   );

   always #2 clock = ~clock;

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [11:0] mirror_low(input logic [11:0] v, input int n);
      logic [11:0] r;
      r = '0;
      for (int i = 0; i < n; i++) begin
         r[n - 1 - i] = v[i];
      end
      return r;
   endfunction

   // Mapper predictor; updates the shadow registers as the hardware would.
   function automatic response_type predict_access(input request_type r);
      response_type res;
      logic [14:0]  prg_offset;
      logic [12:0]  chr_address;
      logic [9:0]   nt_offset;
      logic         page5;
      logic [2:0]   sel;
      logic [11:0]  mirrored;
      res = '0;
      page5 = (r.address[15:12] == REG_PAGE);
      sel = r.address[10:8];
      case (access_mode_type'(r.mode))
         MODE_REG_WRITE: begin
            if (page5) begin
               if (sel == SEL_MODE) shadow_mode = r.data;
               else if (sel == SEL_BANK) shadow_bank = r.data;
               else if (sel == SEL_INDEX) shadow_index = r.data;
            end
         end
         MODE_REG_READ: begin
            if (page5) begin
               if (sel == SEL_TOGGLE) begin
                  shadow_toggle = ~shadow_toggle;
                  res.read_data = {5'b0, shadow_toggle, 2'b0};
               end else if (sel == SEL_PROT) begin
                  res.read_data = (r.open_bus & OPEN_BUS_KEEP) | GUARD_LUT[shadow_index[7:4]];
               end else begin
                  res.read_data = r.open_bus;
               end
            end
         end
         MODE_PRG_ADDR: begin
            prg_offset = r.address[14:0];
            if (shadow_mode[0]) prg_offset[11:0] = mirror_low(prg_offset[11:0], 12);
            res.rom_address = {shadow_mode[6:5], prg_offset};
         end
         MODE_PRG_DATA: begin
            mirrored = mirror_low({4'b0, r.data}, 8);
            res.read_data = shadow_mode[0] ? mirrored[7:0] : r.data;
         end
         MODE_PAT_READ: begin
            chr_address = r.address[12:0];
            if (shadow_mode[7]) begin
               chr_address[3] = shadow_nt_offset[0];
               chr_address[12] = shadow_nt_offset[9];
            end
            res.rom_address = {4'b0, chr_address};
         end
         MODE_NT_READ: begin
            nt_offset = r.address[9:0];
            if (nt_offset < NT_ATTR_START) shadow_nt_offset = nt_offset;
            res.nt_page = shadow_bank[1] ? r.address[10] : r.address[11];
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic request_type random_access();
      request_type r;
      int          pick;
      logic [2:0]  sel_choice [3];
      sel_choice = '{SEL_MODE, SEL_BANK, SEL_INDEX};
      r.address = 16'($urandom);
      r.data = 8'($urandom);
      r.open_bus = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         r.mode = MODE_REG_WRITE;
         if ($urandom_range(0, 4) != 0) begin
            r.address[15:12] = REG_PAGE;
            r.address[10:8] = sel_choice[$urandom_range(0, 2)];
         end
      end else if (pick < 28) begin
         r.mode = MODE_REG_READ;
         if ($urandom_range(0, 4) != 0) r.address[15:12] = REG_PAGE;
      end else if (pick < 46) begin
         r.mode = MODE_PRG_ADDR;
      end else if (pick < 56) begin
         r.mode = MODE_PRG_DATA;
      end else if (pick < 76) begin
         r.mode = MODE_PAT_READ;
      end else if (pick < 95) begin
         r.mode = MODE_NT_READ;
      end else begin
         r.mode = $urandom_range(0, 1) ? MODE_UNUSED6 : MODE_UNUSED7;
      end
      return r;
   endfunction

   task automatic issue(input request_type r, input logic known, input response_type typed);
      response_type predicted;
      req_tvalid <= 1'b1;
      req_tuser <= r.mode;
      req_tdata <= {r.open_bus, r.data, r.address};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_access(r);
      pending_responses.push_back(known ? typed : predicted);
      mode_counts[r.mode] = mode_counts[r.mode] + 1;
   endtask

   task automatic drain();
      while (pending_responses.size() != 0) @(posedge clock);
      drain_count = drain_count + 1;
   endtask

   // Receiver stall pattern cycles through four styles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count / 300) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= ((cycle_count % 7) > 2);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      response_type got;
      response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = response_type'(rsp_tdata[25:0]);
         if (pending_responses.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            mismatch_count = mismatch_count + 1;
         end else begin
            want = pending_responses.pop_front();
            checked_count = checked_count + 1;
            if (got.read_data !== want.read_data) begin
               $error("read_data expected %h actual %h", want.read_data, got.read_data);
               mismatch_count = mismatch_count + 1;
            end
            if (got.rom_address !== want.rom_address) begin
               $error("rom_address expected %h actual %h", want.rom_address, got.rom_address);
               mismatch_count = mismatch_count + 1;
            end
            if (got.nt_page !== want.nt_page) begin
               $error("nt_page expected %b actual %b", want.nt_page, got.nt_page);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   initial begin
      request_type  r;
      response_type typed;
      int           burst_left;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_vectors[i]) begin
         r.mode = directed_vectors[i].mode;
         r.address = directed_vectors[i].address;
         r.data = directed_vectors[i].data;
         r.open_bus = directed_vectors[i].open_bus;
         typed.read_data = directed_vectors[i].read_data;
         typed.rom_address = directed_vectors[i].rom_address;
         typed.nt_page = directed_vectors[i].nt_page;
         issue(r, directed_vectors[i].known, typed);
      end
      req_tvalid <= 1'b0;
      drain();

      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         issue(random_access(), 1'b0, '0);
         burst_left = burst_left - 1;
         if (n % DRAIN_INTERVAL == DRAIN_INTERVAL - 1) begin
            req_tvalid <= 1'b0;
            drain();
            burst_left = $urandom_range(1, 24);
         end else if (burst_left == 0) begin
            // long bursts with no gap in one out of four
            if ($urandom_range(0, 3) == 0) begin
               burst_left = $urandom_range(40, 120);
            end else begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
               burst_left = $urandom_range(1, 24);
            end
         end
      end
      req_tvalid <= 1'b0;
      drain();
      repeat (10) @(posedge clock);

      $display("checked %0d responses over %0d directed and %0d random requests, %0d drains",
               checked_count, DIRECTED_COUNT, RANDOM_COUNT, drain_count);
      $display("requests by mode: wr %0d rd %0d prg %0d data %0d pat %0d nt %0d unused %0d",
               mode_counts[MODE_REG_WRITE], mode_counts[MODE_REG_READ],
               mode_counts[MODE_PRG_ADDR], mode_counts[MODE_PRG_DATA],
               mode_counts[MODE_PAT_READ], mode_counts[MODE_NT_READ],
               mode_counts[MODE_UNUSED6] + mode_counts[MODE_UNUSED7]);
      if (mismatch_count == 0 && pending_responses.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
